[hdl/isr_pkg.sv]
// shared constants and types for the insertion sorter
// used by isr_cell and insertion_sorter; no dependencies

package isr_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    // fill count has to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        S_FILL,
        S_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_down;
    } t_cell_ctl;

endpackage

[hdl/isr_cell.sv]
// one compare-and-shift cell of the sorter chain
// depends on isr_pkg

module isr_cell
    import isr_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occupied,
    input  logic signed [DATA_W-1:0] i_new,
    input  logic signed [DATA_W-1:0] i_prev_val,
    input  logic                     i_prev_gt,
    input  logic signed [DATA_W-1:0] i_next_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // an empty cell counts as larger than anything
    assign o_gt  = !i_occupied || (i_new < r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert && o_gt) begin
            // the left neighbor is also larger: its entry moves up into this cell
            n_val = i_prev_gt ? i_prev_val : i_new;
        end else if (i_ctl.shift_down) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[hdl/insertion_sorter.sv]
// top level of the streaming insertion sorter
// depends on isr_pkg and isr_cell

// Sorts sets of signed 32-bit values. While a set is filling, one value is taken every
// cycle and inserted into a chain of CAPACITY compare-and-shift cells in that same
// cycle; equal values keep their arrival order. The transaction with i_set_end high is
// inserted as well, then the chain drains its n entries in ascending order through an
// output register, one result per cycle when the output is not stalled; o_stall stays
// high while the set drains. Values beyond CAPACITY are dropped and every result of
// that set carries o_overflowed. o_final_res marks the last result of a set.

module insertion_sorter
    import isr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_set_end,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_res,
    output logic                     o_overflowed
);

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_dropped;
    logic                     n_dropped;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_final;
    logic                     r_out_ovf;

    t_cell_ctl                cell_ctl;
    logic                     in_take;
    logic                     full;
    logic                     load;
    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic                     cell_gt  [CAPACITY];
    logic                     cell_occ [CAPACITY];

    assign o_stall = (r_state == S_DRAIN);
    assign in_take = i_valid && !o_stall;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign load    = (r_state == S_DRAIN) && (!r_out_valid || !i_stall);

    assign cell_ctl.insert     = in_take && !full;
    assign cell_ctl.shift_down = load;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign cell_occ[g] = (CNT_W'(g) < r_count);
            if (g == 0) begin : g_head
                isr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl),
                    .i_occupied (cell_occ[g]),
                    .i_new      (i_value),
                    .i_prev_val (i_value),
                    .i_prev_gt  (1'b0),
                    .i_next_val (cell_val[g+1]),
                    .o_val      (cell_val[g]),
                    .o_gt       (cell_gt[g])
                );
            end else if (g == CAPACITY - 1) begin : g_tail
                isr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl),
                    .i_occupied (cell_occ[g]),
                    .i_new      (i_value),
                    .i_prev_val (cell_val[g-1]),
                    .i_prev_gt  (cell_gt[g-1]),
                    .i_next_val ('0),
                    .o_val      (cell_val[g]),
                    .o_gt       (cell_gt[g])
                );
            end else begin : g_mid
                isr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl),
                    .i_occupied (cell_occ[g]),
                    .i_new      (i_value),
                    .i_prev_val (cell_val[g-1]),
                    .i_prev_gt  (cell_gt[g-1]),
                    .i_next_val (cell_val[g+1]),
                    .o_val      (cell_val[g]),
                    .o_gt       (cell_gt[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_val   <= cell_val[0];
            r_out_final <= (r_count == CNT_W'(1));
            r_out_ovf   <= r_dropped;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_FILL: begin
                if (in_take) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_set_end) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state   = S_FILL;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_val;
    assign o_final_res    = r_out_final;
    assign o_overflowed   = r_out_ovf;

`ifndef NO_ASSERTIONS
    // a set being drained always holds at least one entry
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_count != '0))
        else $error("drain with empty chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // the last result of a set ends the drain and clears the drop flag
    a_final_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_count == CNT_W'(1)) |=> (r_state == S_FILL && !r_dropped && o_final_res))
        else $error("final result did not end the drain");

    // no result is loaded while a transaction is still being inserted
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load && in_take))
        else $error("insert and drain in the same cycle");
`endif

endmodule

[test/testbench.sv]
// self-checking testbench for the insertion_sorter block
// depends on isr_pkg and the insertion_sorter rtl, which also needs isr_cell

`timescale 1ns / 100ps

module testbench
    import isr_pkg::*;
();

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     set_end;
    } t_sort_item;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     final_res;
        logic                     overflowed;
    } t_sorted_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_set_end = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_final_res;
    logic                     o_overflowed;

    t_sort_item     pending_items[$];
    t_sorted_result expected_sorted[$];
    t_sort_item     next_item;

    // predictor state
    logic signed [DATA_W-1:0] shadow_store[CAPACITY];
    int                       shadow_fill = 0;
    logic                     shadow_dropped = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_request = 1'b0;
    bit pressure_done    = 1'b0;
    int hold_left        = 0;
    int idle_cycles      = 0;

    int failures        = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int sets_closed     = 0;
    int overflow_sets   = 0;

    insertion_sorter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_set_end      (i_set_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // insert one accepted value; on set end queue the whole set in ascending order
    task automatic insert_and_emit(input logic signed [DATA_W-1:0] value, input logic set_end);
        int pos;
        t_sorted_result res;
        if (shadow_fill >= CAPACITY) begin
            shadow_dropped = 1'b1;
        end else begin
            pos = shadow_fill;
            // strict compare keeps equal values in arrival order
            while (pos > 0 && value < shadow_store[pos-1]) begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = value;
            shadow_fill++;
        end
        if (set_end) begin
            for (int k = 0; k < shadow_fill; k++) begin
                res.value      = shadow_store[k];
                res.final_res  = (k == shadow_fill - 1);
                res.overflowed = shadow_dropped;
                expected_sorted = {expected_sorted, res};
            end
            sets_closed++;
            if (shadow_dropped)
                overflow_sets++;
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    task automatic check_sorted_result();
        t_sorted_result exp_res;
        if (expected_sorted.size() == 0) begin
            $error("unexpected result: sorted_value %0d final_res %0b overflowed %0b",
                   o_sorted_value, o_final_res, o_overflowed);
            failures++;
        end else begin
            exp_res = expected_sorted.pop_front();
            results_checked++;
            if (o_sorted_value !== exp_res.value) begin
                $error("sorted_value: expected %0d, got %0d", exp_res.value, o_sorted_value);
                failures++;
            end
            if (o_final_res !== exp_res.final_res) begin
                $error("final_res: expected %0b, got %0b", exp_res.final_res, o_final_res);
                failures++;
            end
            if (o_overflowed !== exp_res.overflowed) begin
                $error("overflowed: expected %0b, got %0b", exp_res.overflowed, o_overflowed);
                failures++;
            end
        end
    endtask

    // driver: a transaction stays on the bus until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                insert_and_emit(i_value, i_set_end);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    i_value   <= next_item.value;
                    i_set_end <= next_item.set_end;
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_sorted_result();
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (pressure_request && !pressure_done && o_valid) begin
            // long hold-off so the drain stalls and backs up the input
            i_stall       <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("insertion_sorter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic signed [DATA_W-1:0] value, input logic set_end);
        t_sort_item item;
        item.value   = value;
        item.set_end = set_end;
        pending_items = {pending_items, item};
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input int mode);
        case (mode)
            0:       return DATA_W'($urandom);
            1:       return DATA_W'($signed($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(5))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    3:       return '1;
                    4:       return VAL_MIN + 1;
                    default: return DATA_W'($urandom);
                endcase
            end
        endcase
    endfunction

    // random sets: mostly in capacity, some exactly full, some overflowing
    task automatic add_random_sets(input int n_items);
        int added;
        int set_len;
        int mode;
        int pick;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75)
                set_len = $urandom_range(CAPACITY, 1);
            else if (pick < 88)
                set_len = CAPACITY;
            else
                set_len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
            mode = $urandom_range(2);
            for (int k = 0; k < set_len; k++)
                add_item(pick_value(mode), k == set_len - 1);
            added += set_len;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || expected_sorted.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles sometimes, receiver stalls often
        send_idle_pct  = 25;
        recv_stall_pct = 81;
        add_item(VAL_MIN, 1'b1);
        add_item(VAL_MAX, 1'b1);
        add_item(VAL_MAX, 1'b0);
        add_item('1, 1'b0);
        add_item(VAL_MIN, 1'b0);
        add_item('0, 1'b1);
        add_item(VAL_MIN, 1'b0);
        add_item(VAL_MIN, 1'b1);
        // descending pairs fill the store, then the set end value is dropped
        for (int k = 0; k < CAPACITY; k++)
            add_item(100 - 10 * (k / 2), 1'b0);
        add_item(-100, 1'b1);
        add_random_sets(160);
        wait_drained();

        send_idle_pct  = 81;
        recv_stall_pct = 25;
        add_random_sets(160);
        wait_drained();

        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        pressure_request = 1'b1;
        add_random_sets(160);
        wait_drained();

        repeat (20) @(negedge i_clk);
        $display("%0d transactions sent, %0d sorted results checked", items_accepted,
                 results_checked);
        $display("%0d sets closed, %0d of them overflowed", sets_closed, overflow_sets);
        if (failures == 0 && expected_sorted.size() == 0)
            $display("insertion_sorter regression: pass");
        else
            $display("insertion_sorter regression: fail");
        $finish;
    end

endmodule
